// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and the arctangent table for the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QUAT_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int TAB_LEN  = 30;   // entries in the arctangent table
    localparam int ZW       = 35;   // Q30 angle accumulator width
    localparam int M30_W    = 30;   // asin argument magnitude, Q30
    localparam int RAD_W    = 61;   // radicand 1 - s*s in Q60, up to 2^60
    localparam int SQ_STEPS = 31;   // one root bit per stage
    localparam int SQ_W     = 62;   // working width of the root stages
    localparam int ROOT_W   = 31;   // root up to 2^30

    typedef logic signed [ZW-1:0] z_t;

    localparam z_t PI_Q30      = 35'sd3373259426;
    localparam z_t HALF_PI_Q30 = 35'sd1686629713;

    // atan(2^-i) in Q30, truncated
    function automatic z_t atan_tab(input int i);
        z_t v;
        case (i)
            0:       v = 35'sd843314856;
            1:       v = 35'sd497837829;
            2:       v = 35'sd263043836;
            3:       v = 35'sd133525158;
            4:       v = 35'sd67021686;
            5:       v = 35'sd33543515;
            6:       v = 35'sd16775850;
            7:       v = 35'sd8388437;
            8:       v = 35'sd4194282;
            9:       v = 35'sd2097149;
            10:      v = 35'sd1048575;
            11:      v = 35'sd524287;
            12:      v = 35'sd262143;
            13:      v = 35'sd131071;
            14:      v = 35'sd65535;
            15:      v = 35'sd32767;
            16:      v = 35'sd16383;
            17:      v = 35'sd8191;
            18:      v = 35'sd4095;
            19:      v = 35'sd2047;
            20:      v = 35'sd1023;
            21:      v = 35'sd511;
            22:      v = 35'sd255;
            23:      v = 35'sd127;
            24:      v = 35'sd63;
            25:      v = 35'sd31;
            26:      v = 35'sd15;
            27:      v = 35'sd7;
            28:      v = 35'sd3;
            29:      v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/quaternion_to_euler.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Converts an orientation quaternion to ZYX Euler angles (roll, pitch, yaw)
// through a fully pipelined CORDIC datapath.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: quat_w/x/y/z, signed Q2.(QUAT_WIDTH-2), with in_valid and
//   in_ready. Output channel: roll_angle and yaw_angle (radians, signed
//   Q3.(ANGLE_WIDTH-3)), pitch_angle (radians, signed Q2.(ANGLE_WIDTH-3))
//   and pitch_clamped, with out_valid/out_ready. A transfer happens on a
//   rising edge with valid and ready both high.
//   Pipeline: products, sums, asin prep and squaring, then the bit-per-stage
//   square root, the CORDIC and rounding into the output register.
//   Throughput: one quaternion per cycle while the output is not held off;
//   the root and CORDIC stages are each one add and compare deep.
//   Stall: every stage advances together while the output register is empty
//   or being taken; when the receiver holds off with a result waiting, the
//   whole pipe freezes and in_ready drops, so nothing is lost or repeated.
//   Reset: rst_n clears all valid bits at once; the pipe is then empty and
//   in_ready is high.
//   Non-unit quaternions are not normalised; atan2(0,0) gives 0.
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
    parameter int QUAT_WIDTH   = qte_pkg::QUAT_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = qte_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  quat_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic signed [ANGLE_WIDTH-2:0] pitch_angle,
    output logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    output logic                          pitch_clamped
);
    import qte_pkg::*;

    // products are exact, dropped to at most 60 bits at the widest inputs
    localparam int PSHIFT = (2 * QUAT_WIDTH > 60) ? (2 * QUAT_WIDTH - 60) : 0;
    localparam int PW     = 2 * QUAT_WIDTH - PSHIFT;
    localparam int GFRAC  = 2 * (QUAT_WIDTH - 2) - PSHIFT;
    localparam int GW     = PW + 2;               // 2*(a+b) and 1-2*(a+b)
    localparam int SH_R   = (GFRAC >= 30) ? GFRAC - 30 : 0;
    localparam int SH_L   = (GFRAC < 30) ? 30 - GFRAC : 0;
    localparam int N      = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int CL     = N + 1;                // depth of the CORDIC register chain
    localparam int LAT    = 4 + 1 + SQ_STEPS + CL + 1;
    localparam int PIN_W  = 32;                   // pitch CORDIC operand width

    // Q30 -> Q3.(ANGLE_WIDTH-3), round half up
    localparam int    SH        = 30 - (ANGLE_WIDTH - 3);
    localparam longint HALF_L   = longint'(1) << (SH - 1);
    localparam longint LIM_PI_L = (longint'(PI_Q30) + HALF_L) >>> SH;
    localparam longint LIM_HP_L = (longint'(HALF_PI_Q30) + HALF_L) >>> SH;
    localparam z_t    HALF_Z    = z_t'(HALF_L);
    localparam z_t    LIM_PI    = z_t'(LIM_PI_L);
    localparam z_t    LIM_HP    = z_t'(LIM_HP_L);

    localparam logic signed [GW-1:0]    ONE_G   = GW'(1) <<< GFRAC;
    localparam logic [RAD_W-1:0]        ONE_Q60 = RAD_W'(1) << 60;

    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [GW-1:0] sum_t;

    typedef struct packed {
        logic              clamp;
        logic              neg;
        logic [M30_W-1:0]  m30;
        sum_t              sr;
        sum_t              cr;
        sum_t              sy;
        sum_t              cy;
    } tag_t;

    function automatic prod_t mul(input logic signed [QUAT_WIDTH-1:0] a,
                                  input logic signed [QUAT_WIDTH-1:0] b);
        logic signed [2*QUAT_WIDTH-1:0] f;
        f = a * b;
        return PW'(f >>> PSHIFT);
    endfunction

    function automatic z_t to_ang(input z_t z, input z_t lim);
        z_t a;
        a = (z + HALF_Z) >>> SH;
        if (a > lim)
        begin
            a = lim;
        end
        if (a < -lim)
        begin
            a = -lim;
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // pipeline control: one enable for every stage
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: products
    // ------------------------------------------------------------------
    prod_t wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= mul(quat_w, quat_x);
            yz_reg <= mul(quat_y, quat_z);
            xx_reg <= mul(quat_x, quat_x);
            yy_reg <= mul(quat_y, quat_y);
            wz_reg <= mul(quat_w, quat_z);
            xy_reg <= mul(quat_x, quat_y);
            zz_reg <= mul(quat_z, quat_z);
            wy_reg <= mul(quat_w, quat_y);
            zx_reg <= mul(quat_z, quat_x);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sine and cosine terms
    // ------------------------------------------------------------------
    sum_t sr_reg, cr_reg, sy_reg, cy_reg, sp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg <= (GW'(wx_reg) + GW'(yz_reg)) <<< 1;
            cr_reg <= ONE_G - ((GW'(xx_reg) + GW'(yy_reg)) <<< 1);
            sy_reg <= (GW'(wz_reg) + GW'(xy_reg)) <<< 1;
            cy_reg <= ONE_G - ((GW'(yy_reg) + GW'(zz_reg)) <<< 1);
            sp_reg <= (GW'(wy_reg) - GW'(zx_reg)) <<< 1;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: asin prep - saturation test, |s| moved to Q30
    // ------------------------------------------------------------------
    tag_t        tag3_next, tag3_reg;
    sum_t        sp_mag;
    logic [63:0] sp_wide;

    always_comb
    begin
        sp_mag          = sp_reg[GW-1] ? -sp_reg : sp_reg;
        sp_wide         = 64'(unsigned'(sp_mag));
        tag3_next.clamp = (sp_reg >= ONE_G) || (sp_reg <= -ONE_G);
        tag3_next.neg   = sp_reg[GW-1];
        tag3_next.m30   = M30_W'((sp_wide >> SH_R) << SH_L);
        tag3_next.sr    = sr_reg;
        tag3_next.cr    = cr_reg;
        tag3_next.sy    = sy_reg;
        tag3_next.cy    = cy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag3_reg <= tag3_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: s*s in Q60
    // ------------------------------------------------------------------
    tag_t                tag4_reg;
    logic [2*M30_W-1:0]  sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= tag3_reg.m30 * tag3_reg.m30;
            tag4_reg <= tag3_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root of 1 - s*s; the tag keeps roll/yaw terms in step
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    tag_t              tag_sq;

    assign rad = ONE_Q60 - RAD_W'(sq_reg);

    qte_isqrt #(
        .TAG_W ($bits(tag_t))
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .rad_in   (rad),
        .tag_in   (tag4_reg),
        .root_out (root),
        .tag_out  (tag_sq)
    );

    // ------------------------------------------------------------------
    // three CORDICs side by side
    // ------------------------------------------------------------------
    z_t                     z_roll, z_yaw, z_pitch;
    logic signed [PIN_W-1:0] p_y, p_x;

    assign p_y = PIN_W'(tag_sq.m30);
    assign p_x = PIN_W'(root);

    qte_cordic #(
        .IN_W  (GW),
        .STEPS (N)
    ) u_cordic_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (tag_sq.sr),
        .x_in  (tag_sq.cr),
        .z_out (z_roll)
    );

    qte_cordic #(
        .IN_W  (GW),
        .STEPS (N)
    ) u_cordic_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (tag_sq.sy),
        .x_in  (tag_sq.cy),
        .z_out (z_yaw)
    );

    qte_cordic #(
        .IN_W  (PIN_W),
        .STEPS (N)
    ) u_cordic_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (p_y),
        .x_in  (p_x),
        .z_out (z_pitch)
    );

    // pitch saturation flag and sign, delayed alongside the CORDIC
    logic [1:0] flg_reg [0:CL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg[0] <= {tag_sq.clamp, tag_sq.neg};
            for (int i = 1; i < CL; i++)
            begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: round, saturate, put the pitch sign back
    // ------------------------------------------------------------------
    logic                          clamp_d, neg_d;
    z_t                            pz, roll_a, yaw_a, pitch_a;
    logic signed [ANGLE_WIDTH-1:0] roll_reg, yaw_reg;
    logic signed [ANGLE_WIDTH-2:0] pitch_reg;
    logic                          clamp_reg;

    always_comb
    begin
        clamp_d = flg_reg[CL-1][1];
        neg_d   = flg_reg[CL-1][0];
        pz      = neg_d ? -z_pitch : z_pitch;
        roll_a  = to_ang(z_roll, LIM_PI);
        yaw_a   = to_ang(z_yaw, LIM_PI);
        if (clamp_d)
        begin
            // saturated pitch goes through the same rounding as a computed one
            pitch_a = to_ang(neg_d ? -HALF_PI_Q30 : HALF_PI_Q30, LIM_HP);
        end
        else
        begin
            pitch_a = to_ang(pz, LIM_HP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= ANGLE_WIDTH'(roll_a);
            yaw_reg   <= ANGLE_WIDTH'(yaw_a);
            pitch_reg <= (ANGLE_WIDTH - 1)'(pitch_a);
            clamp_reg <= clamp_d;
        end
    end

    assign roll_angle    = roll_reg;
    assign yaw_angle     = yaw_reg;
    assign pitch_angle   = pitch_reg;
    assign pitch_clamped = clamp_reg;

endmodule

// ===== hdl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q30, one micro-rotation a stage.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int IN_W  = 32,
    parameter int STEPS = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] y_in,
    input  logic signed [IN_W-1:0] x_in,
    output qte_pkg::z_t            z_out
);
    import qte_pkg::*;

    // headroom for negation and CORDIC gain
    localparam int XW = IN_W + 2;

    logic signed [XW-1:0] x_reg [0:STEPS-1];
    logic signed [XW-1:0] y_reg [0:STEPS-1];
    z_t                   z_reg [0:STEPS];

    logic signed [XW-1:0] xe, ye, x0_next, y0_next;
    z_t                   z0_next;

    // pre-rotation: fold the left half plane onto the right
    always_comb
    begin
        xe      = XW'(x_in);
        ye      = XW'(y_in);
        x0_next = xe;
        y0_next = ye;
        z0_next = '0;
        if (x_in == '0 && y_in == '0)
        begin
            x0_next = '0;
            y0_next = '0;
        end
        else if (x_in < 0)
        begin
            z0_next = (y_in >= 0) ? PI_Q30 : -PI_Q30;
            x0_next = -xe;
            y0_next = -ye;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [XW-1:0] dx, dy, x_next, y_next;
        z_t                   z_next;

        always_comb
        begin
            dx     = x_reg[i] >>> i;
            dy     = y_reg[i] >>> i;
            x_next = x_reg[i];
            y_next = y_reg[i];
            z_next = z_reg[i];
            // no turn once y has reached zero
            if (y_reg[i] > 0)
            begin
                x_next = x_reg[i] + dy;
                y_next = y_reg[i] - dx;
                z_next = z_reg[i] + atan_tab(i);
            end
            else if (y_reg[i] < 0)
            begin
                x_next = x_reg[i] - dy;
                y_next = y_reg[i] + dx;
                z_next = z_reg[i] - atan_tab(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[i+1] <= z_next;
            end
        end

        if (i < STEPS - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i+1] <= x_next;
                    y_reg[i+1] <= y_next;
                end
            end
        end
    end

    assign z_out = z_reg[STEPS];

endmodule

// ===== hdl/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root of a Q60 radicand, one root bit a stage,
// with a side tag carried in step.
// ----------------------------------------------------------------------------
module qte_isqrt #(
    parameter int TAG_W = 8
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [qte_pkg::RAD_W-1:0]   rad_in,
    input  logic [TAG_W-1:0]            tag_in,
    output logic [qte_pkg::ROOT_W-1:0]  root_out,
    output logic [TAG_W-1:0]            tag_out
);
    import qte_pkg::*;

    logic [RAD_W-1:0] v_reg   [0:SQ_STEPS-1];
    logic [SQ_W-1:0]  r_reg   [1:SQ_STEPS];
    logic [TAG_W-1:0] tag_reg [0:SQ_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]   <= rad_in;
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));

        logic [SQ_W-1:0]  r_cur, trial, r_next;
        logic [RAD_W-1:0] v_next;

        if (k == 0)
        begin : g_first
            assign r_cur = '0;
        end
        else
        begin : g_rest
            assign r_cur = r_reg[k];
        end

        always_comb
        begin
            trial = r_cur + BIT;
            if ({1'b0, v_reg[k]} >= trial)
            begin
                v_next = RAD_W'({1'b0, v_reg[k]} - trial);
                r_next = (r_cur >> 1) + BIT;
            end
            else
            begin
                v_next = v_reg[k];
                r_next = r_cur >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]   <= r_next;
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        if (k < SQ_STEPS - 1)
        begin : g_v
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[k+1] <= v_next;
                end
            end
        end
    end

    assign root_out = ROOT_W'(r_reg[SQ_STEPS]);
    assign tag_out  = tag_reg[SQ_STEPS];

endmodule

// ===== verif/quaternion_to_euler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_tb
// Drives quaternions through the Euler angle pipeline and compares every
// roll, pitch, yaw and clamp flag against a bit-exact CORDIC predictor kept
// in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module quaternion_to_euler_tb;

    import qte_pkg::*;

    localparam int QW      = 16;
    localparam int AW      = 16;
    localparam int STEPS   = 16;
    localparam int LATENCY = 38 + STEPS;
    localparam int AFRAC   = AW - 3;
    localparam int GFRAC   = 2 * (QW - 2);   // no product shift at this width

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-2:0] pitch;
        logic signed [AW-1:0] yaw;
        logic                 clamped;
    } angles_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [AW-1:0] roll_angle;
    logic signed [AW-2:0] pitch_angle;
    logic signed [AW-1:0] yaw_angle;
    logic                 pitch_clamped;

    angles_t angles_due[$];
    int      n_errors;
    bit      quiet;       // long stretch with no idling on either side

    quaternion_to_euler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .roll_angle   (roll_angle),
        .pitch_angle  (pitch_angle),
        .yaw_angle    (yaw_angle),
        .pitch_clamped(pitch_clamped)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // arithmetic shift right: SV >>> on signed longint floors already
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root60(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // vectoring CORDIC, Q30 radians
    function automatic longint vector_angle(longint y, longint x);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            acc = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = floor_shr(x, i);
            dy = floor_shr(y, i);
            if (y > 0)
            begin
                x = x + dy;
                y = y - dx;
                acc = acc + longint'(atan_tab(i));
            end
            else if (y < 0)
            begin
                x = x - dy;
                y = y + dx;
                acc = acc - longint'(atan_tab(i));
            end
        end
        return acc;
    endfunction

    // Q30 to output format: round half up, clamp to +-lim
    function automatic longint rad_to_out(longint a, longint lim_q30);
        int     sh;
        longint half;
        longint lim;
        longint r;
        sh = 30 - AFRAC;
        half = longint'(1) << (sh - 1);
        lim = floor_shr(lim_q30 + half, sh);
        r = floor_shr(a + half, sh);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic angles_t euler_of(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                                         logic signed [QW-1:0] qy, logic signed [QW-1:0] qz);
        longint  w, x, y, z, one, sr, cr, sy, cy, sp, a;
        longint unsigned m, m30, c;
        angles_t res;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        one = longint'(1) << GFRAC;
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        res.roll = AW'(rad_to_out(vector_angle(sr, cr), PI_Q30));
        res.yaw  = AW'(rad_to_out(vector_angle(sy, cy), PI_Q30));
        if (sp >= one || sp <= -one)
        begin
            res.clamped = 1'b1;
            a = (sp > 0) ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
        end
        else
        begin
            res.clamped = 1'b0;
            m = (sp < 0) ? -sp : sp;
            m30 = m << (30 - GFRAC);
            c = root60((64'd1 << 60) - m30 * m30);
            a = vector_angle(longint'(m30), longint'(c));
            if (sp < 0)
                a = -a;
        end
        res.pitch = (AW-1)'(rad_to_out(a, HALF_PI_Q30));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Transfer and check
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_quat(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                             logic signed [QW-1:0] y, logic signed [QW-1:0] z);
        // random gap before the transfer
        while (!quiet && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w   <= w;
        quat_x   <= x;
        quat_y   <= y;
        quat_z   <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted on this edge; prediction queued here
        angles_due.push_back(euler_of(w, x, y, z));
    endtask

    // receiver: ready stalls at random, results checked at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (angles_due.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with nothing outstanding", $time);
                end
                else
                begin
                    angles_t want;
                    want = angles_due.pop_front();
                    if (roll_angle !== want.roll)
                        report_mismatch("roll", roll_angle, want.roll);
                    if (pitch_angle !== want.pitch)
                        report_mismatch("pitch", pitch_angle, want.pitch);
                    if (yaw_angle !== want.yaw)
                        report_mismatch("yaw", yaw_angle, want.yaw);
                    if (pitch_clamped !== want.clamped)
                        report_mismatch("clamp", pitch_clamped, want.clamped);
                end
            end
            out_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    // sender goes idle and waits for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        while (angles_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    localparam logic signed [QW-1:0] ONE  = 16'sd16384;
    localparam logic signed [QW-1:0] HALF = 16'sd8192;
    localparam logic signed [QW-1:0] MAXV = 16'sh7fff;
    localparam logic signed [QW-1:0] MINV = 16'sh8000;

    task automatic test_directed();
        send_quat(0, 0, 0, 0);              // zero quaternion: sine terms zero, cosine terms one
        send_quat(ONE, 0, 0, 0);            // identity
        send_quat(0, ONE, 0, 0);            // roll of pi: negative x axis
        send_quat(0, 0, 0, ONE);            // yaw of pi
        send_quat(0, 0, ONE, 0);            // pitch term zero, both cos negative
        send_quat(11586, 0, 11586, 0);      // pitch term just past one, clamped
        send_quat(11586, 0, -11586, 0);     // same on the negative side
        send_quat(HALF, HALF, HALF, HALF);
        send_quat(HALF, -HALF, HALF, -HALF);
        send_quat(MAXV, MAXV, MAXV, MAXV);  // far from unit
        send_quat(MINV, MINV, MINV, MINV);
        send_quat(MAXV, MINV, MAXV, MINV);
        send_quat(MINV, MAXV, MINV, MAXV);
        send_quat(-1, -1, -1, -1);
        send_quat(1, 1, 1, 1);
        send_quat(ONE, 0, 100, 0);          // small pitch
        send_quat(ONE, 0, -100, 0);
        send_quat(15000, 0, 6000, 0);       // pitch term about 0.67, not clamped
        send_quat(-ONE, 0, 0, 0);
        send_quat(0, -ONE, 0, 0);
    endtask

    task automatic unit_quat();
        // random direction with magnitude near one, reached by scaling
        real    a, b, c, d, n;
        a = real'($urandom_range(65535)) - 32768.0;
        b = real'($urandom_range(65535)) - 32768.0;
        c = real'($urandom_range(65535)) - 32768.0;
        d = real'($urandom_range(65535)) - 32768.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            n = 1.0;
        send_quat(QW'($rtoi(a / n * 16384.0)), QW'($rtoi(b / n * 16384.0)),
                  QW'($rtoi(c / n * 16384.0)), QW'($rtoi(d / n * 16384.0)));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 70)
                unit_quat();
            else
                send_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
        end
    endtask

    task automatic test_back_to_back(int count);
        quiet = 1'b1;
        test_random(count);
        quiet = 1'b0;
    endtask

    // sender holds until the pipe is empty, then restarts
    task automatic test_pause_and_resume();
        test_random(20);
        drain();
        test_random(20);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        n_errors  = 0;
        quiet     = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        quat_w    = '0;
        quat_x    = '0;
        quat_y    = '0;
        quat_z    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(900);
        test_back_to_back(400);
        test_pause_and_resume();
        test_random(590);

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (n_errors == 0 && angles_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // worst case: every cycle stalled many times over the latency
    initial
    begin
        #200000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/qte_pkg.sv
hdl/qte_cordic.sv
hdl/qte_isqrt.sv
hdl/quaternion_to_euler.sv
verif/quaternion_to_euler_tb.sv
